>>> hw/rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 shared package
// Types, constants and small functions used by the message schedule, the
// round datapath and the sequencer.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // Initial chaining values.
  localparam logic [31:0] SHA1_H0 = 32'h67452301;
  localparam logic [31:0] SHA1_H1 = 32'hEFCDAB89;
  localparam logic [31:0] SHA1_H2 = 32'h98BADCFE;
  localparam logic [31:0] SHA1_H3 = 32'h10325476;
  localparam logic [31:0] SHA1_H4 = 32'hC3D2E1F0;

  // Round constants.
  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  // Padding word that follows a message ending on a word boundary.
  localparam logic [31:0] SHA1_PAD_WORD = 32'h80000000;

  // Last round index of a block.
  localparam logic [6:0] SHA1_LAST_ROUND = 7'd79;

  // Index of the last digest word.
  localparam logic [2:0] SHA1_LAST_DIGEST = 3'd4;

  // Round function groups of twenty rounds each.
  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY_A,
    PH_MAJORITY,
    PH_PARITY_B
  } sha1_phase_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic        round_en;    // perform one round this cycle
    logic        round_first; // first round: take a..e from the chaining values
    sha1_phase_t phase;       // round function group
    logic        add_cv;      // fold the working words into the chaining values
    logic        load_iv;     // reload the initial chaining values
    logic [2:0]  sel;         // digest word shown at the output
  } sha1_core_ctrl_t;

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic        push;   // shift in a message or padding word
    logic        shift;  // advance the schedule by one round
    logic [31:0] word;   // word to push
  } sha1_sched_ctrl_t;

  // Round function f(b, c, d).
  function automatic logic [31:0] sha1_f(sha1_phase_t ph, logic [31:0] b,
                                         logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    unique case (ph)
      PH_CHOOSE:   res = (b & c) | (~b & d);
      PH_MAJORITY: res = (b & c) | (b & d) | (c & d);
      default:     res = b ^ c ^ d;
    endcase
    return res;
  endfunction

  // Round constant for a group.
  function automatic logic [31:0] sha1_k(sha1_phase_t ph);
    logic [31:0] res;
    unique case (ph)
      PH_CHOOSE:   res = SHA1_K0;
      PH_PARITY_A: res = SHA1_K1;
      PH_MAJORITY: res = SHA1_K2;
      default:     res = SHA1_K3;
    endcase
    return res;
  endfunction

  // Final partial word: keep the message bytes and append the 0x80 byte.
  // A count of four never reaches this function.
  function automatic logic [31:0] sha1_tail_word(logic [31:0] data, logic [2:0] nb);
    logic [31:0] res;
    unique case (nb)
      3'd1:    res = {data[31:24], 24'h800000};
      3'd2:    res = {data[31:16], 16'h8000};
      3'd3:    res = {data[31:8], 8'h80};
      default: res = SHA1_PAD_WORD;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Word-serial SHA-1 engine: sequencer, padding and length logic on top of
// the message schedule and the shared round datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A message word is transferred at a rising edge where start is high and
//   busy is low. in_first_word starts a new message; in_last_word ends it,
//   with in_valid_bytes giving the message bytes held in that word.
//   A word that neither completes a block nor ends the message is pushed
//   into the schedule and busy stays low. A word that completes a block is
//   loaded, run through 80 rounds of the shared round adder at one round
//   per cycle, and then folded into the chaining values; busy stays high
//   meanwhile, so no new word is taken until that block is done.
//   After the last word the padding and the 64-bit length are pushed one
//   word per cycle, pausing for the rounds and the fold of each block
//   they complete (one or two blocks). The digest then appears as five
//   transfers on consecutive cycles, each marked by out_strobe, h0 first;
//   out_last_result marks h4. The receiver cannot stall; after the last
//   digest word busy falls and the engine has reloaded itself.
//   Reset loads the initial chaining values and clears the fill count and
//   the message length; it is synchronous and active low.
// ----------------------------------------------------------------------------
module sha1_message_digest
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_first_word,
  input  logic        in_last_word,
  output logic        out_strobe,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic [3:0]       fill_r, fill_nxt;
  logic [63:0]      len_r, len_nxt;
  logic             pad80_r, pad80_nxt;
  logic             lenhi_r, lenhi_nxt;
  logic             final_r, final_nxt;
  logic             tail_r, tail_nxt;
  logic [2:0]       cnt_r, cnt_nxt;

  logic             accept;
  logic [2:0]       nb;
  logic [63:0]      len_base;
  logic [63:0]      len_add;
  logic [31:0]      push_word;
  logic             push;
  logic             push_wrap;
  sha1_phase_t      phase;
  sha1_core_ctrl_t  core_ctrl;
  sha1_sched_ctrl_t sched_ctrl;
  logic [31:0]      w_head;
  logic [31:0]      digest;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Byte count of the word, saturated to four and forced to four when not last.
  always_comb begin
    if (!in_last_word || in_valid_bytes > 3'd4) begin
      nb = 3'd4;
    end else begin
      nb = in_valid_bytes;
    end
  end

  // Running bit length; a first word restarts it.
  assign len_base = in_first_word ? 64'd0 : len_r;
  assign len_add  = {58'd0, nb, 3'b000};

  // Round function group from the round counter.
  always_comb begin
    priority if (rnd_r < 7'd20) begin
      phase = PH_CHOOSE;
    end else if (rnd_r < 7'd40) begin
      phase = PH_PARITY_A;
    end else if (rnd_r < 7'd60) begin
      phase = PH_MAJORITY;
    end else begin
      phase = PH_PARITY_B;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    pad80_nxt = pad80_r;
    lenhi_nxt = lenhi_r;
    final_nxt = final_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_word = 32'd0;
    core_ctrl = '{round_en: 1'b0, round_first: 1'b0, phase: phase,
                  add_cv: 1'b0, load_iv: 1'b0, sel: cnt_r};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          push    = 1'b1;
          len_nxt = len_base + len_add;
          core_ctrl.load_iv = in_first_word;
          if (in_last_word && nb != 3'd4) begin
            push_word = sha1_tail_word(in_data_word, nb);
          end else begin
            push_word = in_data_word;
          end
          pad80_nxt = in_last_word && (nb == 3'd4);
          tail_nxt  = in_last_word;
          fill_nxt  = (in_first_word ? 4'd0 : fill_r) + 4'd1;
          if (fill_nxt == 4'd0) begin
            state_nxt = ST_ROUND;
          end else if (in_last_word) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        push = 1'b1;
        priority if (pad80_r) begin
          push_word = SHA1_PAD_WORD;
          pad80_nxt = 1'b0;
        end else if (lenhi_r) begin
          push_word = len_r[31:0];
          final_nxt = 1'b1;
        end else if (fill_r == 4'd14) begin
          push_word = len_r[63:32];
          lenhi_nxt = 1'b1;
        end else begin
          push_word = 32'd0;
        end
        fill_nxt = fill_r + 4'd1;
        if (fill_nxt == 4'd0) begin
          state_nxt = ST_ROUND;
        end
      end

      ST_ROUND: begin
        core_ctrl.round_en    = 1'b1;
        core_ctrl.round_first = (rnd_r == 7'd0);
        if (rnd_r == SHA1_LAST_ROUND) begin
          rnd_nxt   = 7'd0;
          state_nxt = ST_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end

      ST_ADD: begin
        core_ctrl.add_cv = 1'b1;
        priority if (final_r) begin
          cnt_nxt   = 3'd0;
          state_nxt = ST_OUT;
        end else if (tail_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (cnt_r == SHA1_LAST_DIGEST) begin
          core_ctrl.load_iv = 1'b1;
          len_nxt   = 64'd0;
          fill_nxt  = 4'd0;
          tail_nxt  = 1'b0;
          final_nxt = 1'b0;
          lenhi_nxt = 1'b0;
          pad80_nxt = 1'b0;
          cnt_nxt   = 3'd0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign push_wrap  = push && (fill_nxt == 4'd0);
  assign sched_ctrl = '{push: push, shift: core_ctrl.round_en, word: push_word};

  // State and registered control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= 7'd0;
      fill_r  <= 4'd0;
      len_r   <= 64'd0;
      pad80_r <= 1'b0;
      lenhi_r <= 1'b0;
      final_r <= 1'b0;
      tail_r  <= 1'b0;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      pad80_r <= pad80_nxt;
      lenhi_r <= lenhi_nxt;
      final_r <= final_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Message schedule.
  sha1_sched u_sched (
    .clk    (clk),
    .ctrl   (sched_ctrl),
    .w_head (w_head)
  );

  // Round datapath and chaining values.
  sha1_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (core_ctrl),
    .w_in   (w_head),
    .digest (digest)
  );

  // Digest transfer, one word per cycle.
  assign out_strobe      = (state_r == ST_OUT) && !push_wrap;
  assign out_digest_word = digest;
  assign out_word_number = cnt_r;
  assign out_last_result = (cnt_r == SHA1_LAST_DIGEST);

endmodule

>>> hw/rtl/sha1_sched.sv
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Sixteen-word shift line that collects the block and then produces the
// expanded schedule word for each round at its head.
// ----------------------------------------------------------------------------
module sha1_sched
  import sha1_pkg::*;
(
  input  logic             clk,
  input  sha1_sched_ctrl_t ctrl,
  output logic [31:0]      w_head
);

  logic [31:0] sr_r [16];
  logic [31:0] expand;
  logic [31:0] expand_rot;

  // New schedule word from the fixed taps of the line.
  assign expand     = sr_r[13] ^ sr_r[8] ^ sr_r[2] ^ sr_r[0];
  assign expand_rot = {expand[30:0], expand[31]};
  assign w_head     = sr_r[0];

  // Shift the line on a push or on a round; the tail takes the new word.
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.shift) begin
      for (int i = 0; i < 15; i++) begin
        sr_r[i] <= sr_r[i+1];
      end
      sr_r[15] <= ctrl.push ? ctrl.word : expand_rot;
    end
  end

endmodule

>>> hw/rtl/sha1_core.sv
// ----------------------------------------------------------------------------
// SHA-1 round datapath
// Holds the chaining values and the working words and performs one
// compression round per cycle while round_en is high, with a single shared round adder.
// ----------------------------------------------------------------------------
module sha1_core
  import sha1_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  sha1_core_ctrl_t ctrl,
  input  logic [31:0]     w_in,
  output logic [31:0]     digest
);

  logic [31:0] cv_r [5];
  logic [31:0] wk_r [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] t_sum;

  // The first round of a block starts from the chaining values.
  assign a = ctrl.round_first ? cv_r[0] : wk_r[0];
  assign b = ctrl.round_first ? cv_r[1] : wk_r[1];
  assign c = ctrl.round_first ? cv_r[2] : wk_r[2];
  assign d = ctrl.round_first ? cv_r[3] : wk_r[3];
  assign e = ctrl.round_first ? cv_r[4] : wk_r[4];

  // Shared round adder.
  assign t_sum = {a[26:0], a[31:27]} + sha1_f(ctrl.phase, b, c, d) + e
               + sha1_k(ctrl.phase) + w_in;

  // Working words.
  always_ff @(posedge clk) begin
    if (ctrl.round_en) begin
      wk_r[0] <= t_sum;
      wk_r[1] <= a;
      wk_r[2] <= {b[1:0], b[31:2]};
      wk_r[3] <= c;
      wk_r[4] <= d;
    end
  end

  // Chaining values.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.load_iv) begin
      cv_r[0] <= SHA1_H0;
      cv_r[1] <= SHA1_H1;
      cv_r[2] <= SHA1_H2;
      cv_r[3] <= SHA1_H3;
      cv_r[4] <= SHA1_H4;
    end else if (ctrl.add_cv) begin
      for (int i = 0; i < 5; i++) begin
        cv_r[i] <= cv_r[i] + wk_r[i];
      end
    end
  end

  // Digest word selection.
  always_comb begin
    unique case (ctrl.sel)
      3'd0:    digest = cv_r[0];
      3'd1:    digest = cv_r[1];
      3'd2:    digest = cv_r[2];
      3'd3:    digest = cv_r[3];
      3'd4:    digest = cv_r[4];
      default: digest = cv_r[0];
    endcase
  end

endmodule
